### design/ip6rt_pkg.sv
// shared definitions for the ipv6 multibit trie route-update engine
// state codes, status codes, command codes, stride spans and parameter defaults
// no dependencies
package ip6rt_pkg;

    localparam int WIDE_LEVELS_DEF       = 3;
    localparam int WIDE_NODE_COUNT_DEF   = 8;
    localparam int NARROW_NODE_COUNT_DEF = 4096;

    localparam int WIDE_SPAN   = 65536;
    localparam int NARROW_SPAN = 256;
    localparam int MAX_LEN     = 128;
    localparam int HOP_W       = 32;
    localparam int COUNT_W     = 32;

    // command(1) prefix_hi(64) prefix_lo(64) prefix_length(8) hop_value(32) = 169 -> 176
    localparam int IN_W  = 176;
    // status(2) prefix_count(32) = 34 -> 40
    localparam int OUT_W = 40;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_DEL = 1'b1;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_LEN   = 2'd1;
    localparam logic [1:0] STAT_NO_NODES  = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_WRD,
        ST_WCHK,
        ST_WEXP,
        ST_NRD,
        ST_NCHK,
        ST_NEXP,
        ST_DONE
    } state_t;

endpackage

### design/ip6rt_ram.sv
// generic single-clock ram, one write port and one read port, registered read
// no dependencies
module ip6rt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/ipv6_multibit_trie_route_update.sv
// top level of the ipv6 multibit trie route-update engine
// depends on ip6rt_pkg and ip6rt_ram

// Route-update engine for an IPv6 multibit trie: WIDE_LEVELS levels of 16-bit
// stride (65536-entry wide nodes), then 8-bit levels (256-entry narrow nodes).
// Each input beat adds or deletes one prefix and returns exactly one result beat
// with a status and the prefix count after the command. Both entry stores live
// in single-port-write / registered-read rams. After reset the block runs a
// clearing pass over max(WIDE_NODE_COUNT*65536, NARROW_NODE_COUNT*256) entries
// (1048576 with the defaults) with s_tready low; configuration writes are taken
// during that pass. A command for the default route or a bad length passes
// through start, then done. A walk passes through a ram read, then a check and
// update, for each trie level walked; the last stride read-modify-writes
// every covered entry through the ram at one entry per cycle (the span of
// covered entries is up to 32768 for a wide level and up to 128 for a narrow
// one). The done state hands the result to the output register and stalls
// there while an earlier result still waits. The next command is accepted
// while a finished result still waits in the output register.
module ipv6_multibit_trie_route_update #(
    parameter int WIDE_LEVELS       = ip6rt_pkg::WIDE_LEVELS_DEF,
    parameter int WIDE_NODE_COUNT   = ip6rt_pkg::WIDE_NODE_COUNT_DEF,
    parameter int NARROW_NODE_COUNT = ip6rt_pkg::NARROW_NODE_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // command, prefix_hi, prefix_lo, prefix_length, hop_value from bit 0 up
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [ip6rt_pkg::IN_W-1:0]  s_tdata,
    // status, prefix_count from bit 0 up
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ip6rt_pkg::OUT_W-1:0] m_tdata,
    // invalid hop value register
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ip6rt_pkg::HOP_W-1:0] cfg_data
);

    import ip6rt_pkg::*;

    // child index wide enough for either pool
    localparam int NC_W      = $clog2(NARROW_NODE_COUNT);
    localparam int WC_W      = (WIDE_NODE_COUNT > 1) ? $clog2(WIDE_NODE_COUNT) : 1;
    localparam int CHILD_W   = (NC_W > WC_W) ? NC_W : WC_W;
    localparam int WDEPTH    = WIDE_NODE_COUNT * WIDE_SPAN;
    localparam int NDEPTH    = NARROW_NODE_COUNT * NARROW_SPAN;
    localparam int WA_W      = $clog2(WDEPTH);
    localparam int NA_W      = $clog2(NDEPTH);
    // wide entry: valid, wide flag, child, hop
    localparam int WE_W      = CHILD_W + HOP_W + 2;
    // narrow entry: valid, child, hop
    localparam int NE_W      = CHILD_W + HOP_W + 1;
    localparam int CLR_DEPTH = (WDEPTH > NDEPTH) ? WDEPTH : NDEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH + 1);
    localparam int WU_W      = $clog2(WIDE_NODE_COUNT + 1);
    localparam int NU_W      = $clog2(NARROW_NODE_COUNT + 1);
    localparam int LVL_W     = $clog2(WIDE_LEVELS + 1);

    // control state
    state_t              state_reg, state_next;
    logic [CLR_W-1:0]    clr_reg, clr_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [WU_W-1:0]     wused_reg, wused_next;
    logic [NU_W-1:0]     nused_reg, nused_next;
    logic [HOP_W-1:0]    inval_reg, inval_next;
    logic                pend_reg, pend_next;

    // payload
    logic                cmd_reg, cmd_next;
    logic [63:0]         hi_reg, hi_next;
    logic [63:0]         lo_reg, lo_next;
    logic [7:0]          len_reg, len_next;
    logic [HOP_W-1:0]    hop_reg, hop_next;
    logic [7:0]          depth_reg, depth_next;
    logic [CHILD_W-1:0]  node_reg, node_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [1:0]          stat_reg, stat_next;
    logic [16:0]         span_reg, span_next;
    logic [16:0]         rd_cnt_reg, rd_cnt_next;
    logic [15:0]         base_reg, base_next;
    logic [15:0]         pend_idx_reg, pend_idx_next;
    logic [OUT_W-1:0]    m_tdata_reg, m_tdata_next;

    // ram ports
    logic                w_we, n_we;
    logic [WA_W-1:0]     w_waddr, w_raddr;
    logic [NA_W-1:0]     n_waddr, n_raddr;
    logic [WE_W-1:0]     w_wdata, w_rdata;
    logic [NE_W-1:0]     n_wdata, n_rdata;

    // stride selection
    logic [127:0]        pfx;
    logic [7:0]          pbyte [16];
    logic [3:0]          bsel;
    logic [15:0]         widx;
    logic [7:0]          nidx;
    logic [7:0]          rem;
    logic                w_last, n_last;
    logic [16:0]         w_span, n_span;
    logic [15:0]         exp_idx;
    logic                exp_issue;
    logic                is_del;
    logic [COUNT_W-1:0]  cnt_up, cnt_dn, cnt_done;

    // fields of the entry just read
    logic                w_valid, w_wide;
    logic [CHILD_W-1:0]  w_child, n_child;
    logic                n_valid;

    ip6rt_ram #(.WIDTH(WE_W), .DEPTH(WDEPTH)) u_wide_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    ip6rt_ram #(.WIDTH(NE_W), .DEPTH(NDEPTH)) u_narrow_ram (
        .aclk  (aclk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    // address bytes, first byte of the address in byte 0
    assign pfx = {hi_reg, lo_reg};
    always_comb begin
        for (int k = 0; k < 16; k++) begin
            pbyte[k] = pfx[127 - 8*k -: 8];
        end
    end

    // strides are byte aligned, so the walk depth picks whole bytes
    assign bsel = depth_reg[6:3];
    assign widx = {pbyte[bsel], pbyte[bsel + 4'd1]};
    assign nidx = pbyte[bsel];
    assign rem  = len_reg - depth_reg;

    // last stride when the prefix ends inside it
    assign w_last = ({1'b0, depth_reg} + 9'd16) >= {1'b0, len_reg};
    assign n_last = ({1'b0, depth_reg} + 9'd8)  >= {1'b0, len_reg};
    assign w_span = 17'd1 << (5'd16 - rem[4:0]);
    assign n_span = 17'd1 << (5'd8 - rem[4:0]);

    assign exp_idx   = base_reg | rd_cnt_reg[15:0];
    assign exp_issue = (rd_cnt_reg != span_reg);

    assign w_valid = w_rdata[WE_W-1];
    assign w_wide  = w_rdata[WE_W-2];
    assign w_child = w_rdata[HOP_W +: CHILD_W];
    assign n_valid = n_rdata[NE_W-1];
    assign n_child = n_rdata[HOP_W +: CHILD_W];

    assign is_del   = (cmd_reg == CMD_DEL);
    // saturating count, floors at zero
    assign cnt_up   = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
    assign cnt_dn   = (cnt_reg == '0) ? cnt_reg : cnt_reg - 1'b1;
    assign cnt_done = is_del ? cnt_dn : cnt_up;

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        cnt_next      = cnt_reg;
        wused_next    = wused_reg;
        nused_next    = nused_reg;
        inval_next    = inval_reg;
        pend_next     = 1'b0;
        cmd_next      = cmd_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        len_next      = len_reg;
        hop_next      = hop_reg;
        depth_next    = depth_reg;
        node_next     = node_reg;
        lvl_next      = lvl_reg;
        stat_next     = stat_reg;
        span_next     = span_reg;
        rd_cnt_next   = rd_cnt_reg;
        base_next     = base_reg;
        pend_idx_next = pend_idx_reg;
        m_tdata_next  = m_tdata_reg;

        w_we    = 1'b0;
        n_we    = 1'b0;
        w_waddr = WA_W'({node_reg, widx});
        n_waddr = NA_W'({node_reg, nidx});
        w_raddr = WA_W'({node_reg, widx});
        n_raddr = NA_W'({node_reg, nidx});
        w_wdata = w_rdata;
        n_wdata = n_rdata;

        if (cfg_valid) begin
            inval_next = cfg_data;
        end

        case (state_reg)
            // zero both stores one entry per cycle
            ST_CLEAR: begin
                w_we     = (clr_reg < CLR_W'(WDEPTH));
                n_we     = (clr_reg < CLR_W'(NDEPTH));
                w_waddr  = WA_W'(clr_reg);
                n_waddr  = NA_W'(clr_reg);
                w_wdata  = '0;
                n_wdata  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(CLR_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tdata[0];
                    hi_next    = s_tdata[64:1];
                    lo_next    = s_tdata[128:65];
                    len_next   = s_tdata[136:129];
                    hop_next   = s_tdata[168:137];
                    state_next = ST_START;
                end
            end

            ST_START: begin
                depth_next = '0;
                node_next  = '0;
                lvl_next   = '0;
                if (len_reg > 8'(MAX_LEN)) begin
                    stat_next  = STAT_BAD_LEN;
                    state_next = ST_DONE;
                end else if (len_reg == 8'd0) begin
                    // default route lives on the lookup side, only the count moves here
                    stat_next  = STAT_OK;
                    cnt_next   = cnt_done;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_WRD;
                end
            end

            ST_WRD: begin
                state_next = ST_WCHK;
            end

            ST_WCHK: begin
                if (w_last) begin
                    // partial stride: expand over every covered entry
                    span_next   = w_span;
                    base_next   = widx & ~(16'(w_span - 17'd1));
                    rd_cnt_next = '0;
                    state_next  = ST_WEXP;
                end else if (is_del && w_child == '0 && !w_wide) begin
                    stat_next  = STAT_NOT_FOUND;
                    state_next = ST_DONE;
                end else if (!is_del && w_child == '0) begin
                    if ((lvl_reg + 1'b1) < LVL_W'(WIDE_LEVELS)) begin
                        if (wused_reg >= WU_W'(WIDE_NODE_COUNT)) begin
                            stat_next  = STAT_NO_NODES;
                            state_next = ST_DONE;
                        end else begin
                            w_we       = 1'b1;
                            w_wdata    = {w_valid, 1'b1, CHILD_W'(wused_reg),
                                          w_rdata[HOP_W-1:0]};
                            wused_next = wused_reg + 1'b1;
                            node_next  = CHILD_W'(wused_reg);
                            depth_next = depth_reg + 8'd16;
                            lvl_next   = lvl_reg + 1'b1;
                            state_next = ST_WRD;
                        end
                    end else begin
                        if (nused_reg >= NU_W'(NARROW_NODE_COUNT)) begin
                            stat_next  = STAT_NO_NODES;
                            state_next = ST_DONE;
                        end else begin
                            w_we       = 1'b1;
                            w_wdata    = {w_valid, 1'b0, CHILD_W'(nused_reg),
                                          w_rdata[HOP_W-1:0]};
                            nused_next = nused_reg + 1'b1;
                            node_next  = CHILD_W'(nused_reg);
                            depth_next = depth_reg + 8'd16;
                            lvl_next   = lvl_reg + 1'b1;
                            state_next = ST_NRD;
                        end
                    end
                end else begin
                    // existing child
                    node_next  = w_child;
                    depth_next = depth_reg + 8'd16;
                    lvl_next   = lvl_reg + 1'b1;
                    if ((lvl_reg + 1'b1) < LVL_W'(WIDE_LEVELS)) begin
                        state_next = ST_WRD;
                    end else begin
                        state_next = ST_NRD;
                    end
                end
            end

            // read one entry ahead while the previous one is written back
            ST_WEXP: begin
                w_raddr = WA_W'({node_reg, exp_idx});
                if (exp_issue) begin
                    rd_cnt_next   = rd_cnt_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = exp_idx;
                end
                if (pend_reg) begin
                    w_we    = 1'b1;
                    w_waddr = WA_W'({node_reg, pend_idx_reg});
                    w_wdata = is_del ? {1'b0, w_wide, w_child, inval_reg}
                                     : {1'b1, w_wide, w_child, hop_reg};
                end
                if (!exp_issue && !pend_reg) begin
                    stat_next  = STAT_OK;
                    cnt_next   = cnt_done;
                    state_next = ST_DONE;
                end
            end

            ST_NRD: begin
                state_next = ST_NCHK;
            end

            ST_NCHK: begin
                if (n_last) begin
                    span_next   = n_span;
                    base_next   = {8'd0, nidx & ~(8'(n_span - 17'd1))};
                    rd_cnt_next = '0;
                    state_next  = ST_NEXP;
                end else if (n_child == '0) begin
                    if (is_del) begin
                        stat_next  = STAT_NOT_FOUND;
                        state_next = ST_DONE;
                    end else if (nused_reg >= NU_W'(NARROW_NODE_COUNT)) begin
                        stat_next  = STAT_NO_NODES;
                        state_next = ST_DONE;
                    end else begin
                        n_we       = 1'b1;
                        n_wdata    = {n_valid, CHILD_W'(nused_reg), n_rdata[HOP_W-1:0]};
                        nused_next = nused_reg + 1'b1;
                        node_next  = CHILD_W'(nused_reg);
                        depth_next = depth_reg + 8'd8;
                        state_next = ST_NRD;
                    end
                end else begin
                    node_next  = n_child;
                    depth_next = depth_reg + 8'd8;
                    state_next = ST_NRD;
                end
            end

            ST_NEXP: begin
                n_raddr = NA_W'({node_reg, exp_idx[7:0]});
                if (exp_issue) begin
                    rd_cnt_next   = rd_cnt_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = exp_idx;
                end
                if (pend_reg) begin
                    n_we    = 1'b1;
                    n_waddr = NA_W'({node_reg, pend_idx_reg[7:0]});
                    n_wdata = is_del ? {1'b0, n_child, inval_reg}
                                     : {1'b1, n_child, hop_reg};
                end
                if (!exp_issue && !pend_reg) begin
                    stat_next  = STAT_OK;
                    cnt_next   = cnt_done;
                    state_next = ST_DONE;
                end
            end

            // hand the result to the output register once it is free
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, cnt_reg, stat_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
            wused_reg    <= WU_W'(1);
            nused_reg    <= NU_W'(1);
            inval_reg    <= '1;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
            wused_reg    <= wused_next;
            nused_reg    <= nused_next;
            inval_reg    <= inval_next;
            pend_reg     <= pend_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        len_reg      <= len_next;
        hop_reg      <= hop_next;
        depth_reg    <= depth_next;
        node_reg     <= node_next;
        lvl_reg      <= lvl_next;
        stat_reg     <= stat_next;
        span_reg     <= span_next;
        rd_cnt_reg   <= rd_cnt_next;
        base_reg     <= base_next;
        pend_idx_reg <= pend_idx_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // expansion never reads the entry whose write-back is pending
    a_exp_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_WEXP || state_reg == ST_NEXP) && pend_reg && exp_issue)
        |-> (exp_idx != pend_idx_reg))
        else $error("expansion read hits pending write");

    // pools stay within their node counts
    a_wide_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        (wused_reg >= WU_W'(1)) && (wused_reg <= WU_W'(WIDE_NODE_COUNT)))
        else $error("wide pool out of range");

    a_narrow_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        (nused_reg >= NU_W'(1)) && (nused_reg <= NU_W'(NARROW_NODE_COUNT)))
        else $error("narrow pool out of range");

    // an accepted command always moves to the start state
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_START))
        else $error("accepted beat did not start");

    // a result appears only out of the done state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result without finished command");

endmodule
